### src/teq_pkg.sv
// shared types, codes and constants of the timed event queue
package teq_pkg;

	localparam int DEF_QUEUE_DEPTH = 16;

	// request codes
	localparam logic [1:0] FUNC_INSERT     = 2'd0;
	localparam logic [1:0] FUNC_POLL       = 2'd1;
	localparam logic [1:0] FUNC_WAKE_POST  = 2'd2;
	localparam logic [1:0] FUNC_WAKE_CLEAR = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	// stored event kinds
	localparam logic [1:0] EV_READY    = 2'd0;
	localparam logic [1:0] EV_IO_DONE  = 2'd1;
	localparam logic [1:0] EV_CALLBACK = 2'd2;
	localparam logic [1:0] EV_BAD      = 2'd3;

	// result kinds
	localparam logic [2:0] RK_NONE     = 3'd0;
	localparam logic [2:0] RK_WAKEUP   = 3'd1;
	localparam logic [2:0] RK_EV_BASE  = 3'd2;

	// most caller slots one poll may fill
	localparam logic [5:0] MAX_SLOTS = 6'd32;

	typedef struct packed {
		logic [62:0] due;
		logic [1:0]  kind;
		logic [31:0] tag;
		logic [31:0] value;
	} entry_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] tag;
		logic [31:0] value;
	} res_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic decode;
		logic ins_step;
		logic ins_final;
		logic poll_step;
		logic poll_final;
		logic out_single;
		logic out_wake;
		logic out_res;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] func;
		logic       dec_ok;
		logic       scan_done;
		logic       wk_res;
		logic       res_none;
		logic       res_last;
	} sts_t;

endpackage

### src/timed_event_queue_core.sv
// top level of the timed event queue: controller plus datapath
//
// channel   direction  handshake                    payload
// request   in         start && !busy accepts       func, due_time, event_kind, event_tag,
//                                                   event_value, swizzle_coin, now_time,
//                                                   max_events
// result    out        strobe, one cycle each       status, result_kind, result_tag,
//                                                   result_value, last, next_due
//
// insert reads and then processes each of the n stored entries, then writes the new one
// poll reads and processes each stored entry to scan and compact, then gives the wakeup
// if one was posted and then each delivered event, or an empty result if there are neither
// wakeup post and clear decode and then report; each result is registered onto the ports
// arst_n clears count, wakeup flag and state; entry storage is not cleared
// the receiver cannot stall; every transaction is seen on strobe as it is shown
module timed_event_queue_core import teq_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         func,
	input  logic [62:0]        due_time,
	input  logic [1:0]         event_kind,
	input  logic [31:0]        event_tag,
	input  logic signed [31:0] event_value,
	input  logic               swizzle_coin,
	input  logic [62:0]        now_time,
	input  logic [5:0]         max_events,
	output logic               strobe,
	output logic [1:0]         status,
	output logic [2:0]         result_kind,
	output logic [31:0]        result_tag,
	output logic signed [31:0] result_value,
	output logic               last,
	output logic signed [63:0] next_due
);

	cmd_t cmd;
	sts_t sts;

	// sequencing
	teq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	// storage and result path
	teq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.func         (func),
		.due_time     (due_time),
		.event_kind   (event_kind),
		.event_tag    (event_tag),
		.event_value  (event_value),
		.swizzle_coin (swizzle_coin),
		.now_time     (now_time),
		.max_events   (max_events),
		.strobe       (strobe),
		.status       (status),
		.result_kind  (result_kind),
		.result_tag   (result_tag),
		.result_value (result_value),
		.last         (last),
		.next_due     (next_due)
	);

endmodule

### src/teq_dp.sv
// datapath of the timed event queue: entry memory, result buffer, output registers
module teq_dp import teq_pkg::*; #(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic [1:0]         func,
	input  logic [62:0]        due_time,
	input  logic [1:0]         event_kind,
	input  logic [31:0]        event_tag,
	input  logic signed [31:0] event_value,
	input  logic               swizzle_coin,
	input  logic [62:0]        now_time,
	input  logic [5:0]         max_events,
	output logic               strobe,
	output logic [1:0]         status,
	output logic [2:0]         result_kind,
	output logic [31:0]        result_tag,
	output logic signed [31:0] result_value,
	output logic               last,
	output logic signed [63:0] next_due
);

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

	// latched request
	logic [1:0]  func_q;
	logic [62:0] due_q;
	logic [1:0]  kind_q;
	logic [31:0] tag_q;
	logic [31:0] val_q;
	logic        coin_q;
	logic [62:0] now_q;
	logic [5:0]  maxev_q;

	// queue state
	entry_t      ent_mem [QUEUE_DEPTH];
	entry_t      ent_rd_q;
	res_t        res_mem [QUEUE_DEPTH];
	res_t        res_rd_q;
	logic [CW-1:0] count_q;
	logic          wake_q;
	logic [63:0]   nd_q;

	// scan state
	logic [CW-1:0] idx_q;
	logic [CW-1:0] w_q;
	logic [CW-1:0] rc_q;
	logic [CW-1:0] k_q;
	logic [5:0]    used_q;
	logic          ins_on_q;
	logic          wk_res_q;
	logic          any_q;
	logic [62:0]   min_q;
	entry_t        carry_q;
	logic [1:0]    st_q;

	// output registers
	logic          strobe_q;
	logic [1:0]    status_q;
	logic [2:0]    rkind_q;
	logic [31:0]   rtag_q;
	logic [31:0]   rval_q;
	logic          last_q;
	logic [63:0]   rnd_q;

	logic          dec_ok;
	logic [1:0]    dec_st;
	logic          gt;
	logic          take;
	logic          ent_we;
	logic [AW-1:0] ent_waddr;
	entry_t        ent_wdata;
	entry_t        new_ent;

	assign new_ent = '{due: due_q, kind: kind_q, tag: tag_q, value: val_q};
	assign gt      = ent_rd_q.due > due_q;
	assign take    = (ent_rd_q.due <= now_q) && (used_q < maxev_q);

	// request check
	always_comb begin
		dec_ok = 1'b1;
		dec_st = ST_OK;
		case (func_q)
			FUNC_INSERT: begin
				if (kind_q == EV_BAD) begin
					dec_ok = 1'b0;
					dec_st = ST_INVALID;
				end else if (count_q == DEPTH_C) begin
					dec_ok = 1'b0;
					dec_st = ST_FULL;
				end
			end
			FUNC_POLL: begin
				if (maxev_q == 6'd0) begin
					dec_ok = 1'b0;
					dec_st = ST_INVALID;
				end
			end
			default: begin
				dec_ok = 1'b1;
				dec_st = ST_OK;
			end
		endcase
	end

	// entry memory write select
	always_comb begin
		ent_we    = 1'b0;
		ent_waddr = idx_q[AW-1:0];
		ent_wdata = carry_q;
		if (cmd.ins_step && (ins_on_q || (gt && !coin_q))) begin
			ent_we = 1'b1;
		end else if (cmd.ins_final) begin
			ent_we    = 1'b1;
			ent_waddr = count_q[AW-1:0];
		end else if (cmd.poll_step && !take) begin
			ent_we    = 1'b1;
			ent_waddr = w_q[AW-1:0];
			ent_wdata = ent_rd_q;
		end
	end

	// memories
	always_ff @(posedge clk) begin
		if (ent_we)
			ent_mem[ent_waddr] <= ent_wdata;
		ent_rd_q <= ent_mem[idx_q[AW-1:0]];
		if (cmd.poll_step && take)
			res_mem[rc_q[AW-1:0]] <= '{kind: {1'b0, ent_rd_q.kind} + RK_EV_BASE,
				tag: ent_rd_q.tag, value: ent_rd_q.value};
		res_rd_q <= res_mem[k_q[AW-1:0]];
	end

	// request latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= func;
			due_q   <= due_time;
			kind_q  <= event_kind;
			tag_q   <= event_tag;
			val_q   <= event_value;
			coin_q  <= swizzle_coin;
			now_q   <= now_time;
			maxev_q <= (max_events > MAX_SLOTS) ? MAX_SLOTS : max_events;
		end
	end

	// scan bookkeeping
	always_ff @(posedge clk) begin
		if (cmd.decode) begin
			st_q     <= dec_st;
			idx_q    <= '0;
			w_q      <= '0;
			k_q      <= '0;
			ins_on_q <= 1'b0;
			carry_q  <= new_ent;
			any_q    <= 1'b0;
		end
		if (cmd.ins_step) begin
			idx_q <= idx_q + 1'b1;
			if (ins_on_q || (gt && !coin_q)) begin
				carry_q  <= ent_rd_q;
				ins_on_q <= 1'b1;
			end else if (gt) begin
				ins_on_q <= 1'b1;
			end
		end
		if (cmd.poll_step) begin
			idx_q <= idx_q + 1'b1;
			if (!take) begin
				w_q <= w_q + 1'b1;
				if (!any_q || ent_rd_q.due < min_q) begin
					min_q <= ent_rd_q.due;
					any_q <= 1'b1;
				end
			end
		end
		if (cmd.out_res)
			k_q <= k_q + 1'b1;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			wake_q   <= 1'b0;
			nd_q     <= '1;
			rc_q     <= '0;
			used_q   <= '0;
			wk_res_q <= 1'b0;
		end else begin
			if (cmd.decode) begin
				rc_q     <= '0;
				used_q   <= '0;
				wk_res_q <= 1'b0;
				if (func_q == FUNC_WAKE_POST)
					wake_q <= 1'b1;
				else if (func_q == FUNC_WAKE_CLEAR)
					wake_q <= 1'b0;
				else if (func_q == FUNC_POLL && dec_ok) begin
					wk_res_q <= wake_q;
					used_q   <= {5'b0, wake_q};
					wake_q   <= 1'b0;
				end
			end
			if (cmd.poll_step && take) begin
				rc_q <= rc_q + 1'b1;
				if (ent_rd_q.kind != EV_CALLBACK)
					used_q <= used_q + 6'd1;
			end
			if (cmd.ins_final) begin
				count_q <= count_q + 1'b1;
				if (nd_q[63] || ({1'b0, due_q} < nd_q))
					nd_q <= {1'b0, due_q};
			end
			if (cmd.poll_final) begin
				count_q <= w_q;
				nd_q    <= any_q ? {1'b0, min_q} : '1;
			end
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			strobe_q <= 1'b0;
		else
			strobe_q <= cmd.out_single || cmd.out_wake || cmd.out_res;
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.out_single || cmd.out_wake || cmd.out_res) begin
			status_q <= st_q;
			rnd_q    <= nd_q;
		end
		if (cmd.out_single) begin
			rkind_q <= RK_NONE;
			rtag_q  <= '0;
			rval_q  <= '0;
			last_q  <= 1'b1;
		end else if (cmd.out_wake) begin
			rkind_q <= RK_WAKEUP;
			rtag_q  <= '0;
			rval_q  <= '0;
			last_q  <= (rc_q == '0);
		end else if (cmd.out_res) begin
			rkind_q <= res_rd_q.kind;
			rtag_q  <= res_rd_q.tag;
			rval_q  <= res_rd_q.value;
			last_q  <= (k_q + 1'b1 == rc_q);
		end
	end

	assign sts.func      = func_q;
	assign sts.dec_ok    = dec_ok;
	assign sts.scan_done = (idx_q == count_q);
	assign sts.wk_res    = wk_res_q;
	assign sts.res_none  = (rc_q == '0);
	assign sts.res_last  = (k_q + 1'b1 == rc_q);

	assign strobe       = strobe_q;
	assign status       = status_q;
	assign result_kind  = rkind_q;
	assign result_tag   = rtag_q;
	assign result_value = rval_q;
	assign last         = last_q;
	assign next_due     = rnd_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C) else $error("entry count above depth");
	a_compact_safe: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.poll_step |-> w_q <= idx_q) else $error("compaction write overtakes read");
	a_slots_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.poll_step |-> used_q <= maxev_q) else $error("poll used too many slots");
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && last_q |=> !strobe_q) else $error("result right after last");
`endif

endmodule

### src/teq_ctrl.sv
// controller state machine of the timed event queue
module teq_ctrl import teq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DEC    = 4'd1;
	localparam logic [3:0] S_INS_RD = 4'd2;
	localparam logic [3:0] S_INS_PR = 4'd3;
	localparam logic [3:0] S_POL_RD = 4'd4;
	localparam logic [3:0] S_POL_PR = 4'd5;
	localparam logic [3:0] S_OUT1   = 4'd6;
	localparam logic [3:0] S_EMW    = 4'd7;
	localparam logic [3:0] S_EMR    = 4'd8;
	localparam logic [3:0] S_EMO    = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DEC;
				end
			end
			S_DEC: begin
				cmd.decode = 1'b1;
				if (sts.dec_ok && sts.func == FUNC_INSERT)
					state_d = S_INS_RD;
				else if (sts.dec_ok && sts.func == FUNC_POLL)
					state_d = S_POL_RD;
				else
					state_d = S_OUT1;
			end
			S_INS_RD: begin
				if (sts.scan_done) begin
					cmd.ins_final = 1'b1;
					state_d       = S_OUT1;
				end else begin
					state_d = S_INS_PR;
				end
			end
			S_INS_PR: begin
				cmd.ins_step = 1'b1;
				state_d      = S_INS_RD;
			end
			S_POL_RD: begin
				if (sts.scan_done) begin
					cmd.poll_final = 1'b1;
					if (sts.wk_res)
						state_d = S_EMW;
					else if (sts.res_none)
						state_d = S_OUT1;
					else
						state_d = S_EMR;
				end else begin
					state_d = S_POL_PR;
				end
			end
			S_POL_PR: begin
				cmd.poll_step = 1'b1;
				state_d       = S_POL_RD;
			end
			S_OUT1: begin
				cmd.out_single = 1'b1;
				state_d        = S_IDLE;
			end
			S_EMW: begin
				cmd.out_wake = 1'b1;
				state_d      = sts.res_none ? S_IDLE : S_EMR;
			end
			S_EMR: begin
				state_d = S_EMO;
			end
			S_EMO: begin
				cmd.out_res = 1'b1;
				state_d     = sts.res_last ? S_IDLE : S_EMR;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign busy = (state_q != S_IDLE);

`ifndef ASSERT_OFF
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted transaction without going busy");
	a_one_output: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({cmd.out_single, cmd.out_wake, cmd.out_res}) <= 1)
		else $error("two results in one cycle");
	a_scan_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.ins_step && cmd.poll_step)) else $error("insert and poll scan together");
`endif

endmodule

### tb/sv/timed_event_queue_checker.sv
// checker for the timed event queue: predicts results and compares them
`timescale 1ns / 1ps
module timed_event_queue_checker import teq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         func,
	input  logic [62:0]        due_time,
	input  logic [1:0]         event_kind,
	input  logic [31:0]        event_tag,
	input  logic signed [31:0] event_value,
	input  logic               swizzle_coin,
	input  logic [62:0]        now_time,
	input  logic [5:0]         max_events,
	input  logic               strobe,
	input  logic [1:0]         status,
	input  logic [2:0]         result_kind,
	input  logic [31:0]        result_tag,
	input  logic signed [31:0] result_value,
	input  logic               last,
	input  logic signed [63:0] next_due,
	output int                 fail_count,
	output int                 pending
);

	localparam int DEPTH = DEF_QUEUE_DEPTH;

	typedef struct packed {
		logic [1:0]  status;
		logic [2:0]  kind;
		logic [31:0] tag;
		logic [31:0] value;
		logic        last;
		logic [63:0] next_due;
	} outcome_t;

	entry_t   stored [DEPTH];
	int       stored_count;
	logic     wake_flag;
	outcome_t expected_q [$];

	assign pending = expected_q.size();

	// earliest due time among stored events
	function automatic logic [63:0] earliest();
		logic [63:0] best;
		best = '1;
		for (int i = 0; i < stored_count; i++)
			if (best == '1 || {1'b0, stored[i].due} < best)
				best = {1'b0, stored[i].due};
		return best;
	endfunction

	// apply one request transaction to the predicted queue
	task automatic predict_request();
		outcome_t res [$];
		outcome_t o;
		int p;
		int used;
		int i;
		int lim;
		logic [63:0] nd;
		o = '0;
		case (func)
			FUNC_INSERT: begin
				if (event_kind == EV_BAD)
					o.status = ST_INVALID;
				else if (stored_count >= DEPTH)
					o.status = ST_FULL;
				else begin
					p = 0;
					while (p < stored_count && stored[p].due <= due_time)
						p++;
					if (swizzle_coin && p < stored_count)
						p++;
					for (int j = stored_count; j > p; j--)
						stored[j] = stored[j - 1];
					stored[p] = '{due_time, event_kind, event_tag, event_value};
					stored_count++;
					o.status = ST_OK;
				end
				res.push_back(o);
			end
			FUNC_POLL: begin
				if (max_events == 0) begin
					o.status = ST_INVALID;
					res.push_back(o);
				end else begin
					lim = (max_events > MAX_SLOTS) ? MAX_SLOTS : max_events;
					used = 0;
					i = 0;
					if (wake_flag) begin
						wake_flag = 1'b0;
						o.kind = RK_WAKEUP;
						res.push_back(o);
						used++;
					end
					while (i < stored_count && used < lim) begin
						if (stored[i].due > now_time) begin
							i++;
						end else begin
							o = '0;
							o.kind = {1'b0, stored[i].kind} + RK_EV_BASE;
							o.tag = stored[i].tag;
							o.value = stored[i].value;
							res.push_back(o);
							if (stored[i].kind != EV_CALLBACK)
								used++;
							for (int j = i; j + 1 < stored_count; j++)
								stored[j] = stored[j + 1];
							stored_count--;
						end
					end
					if (res.size() == 0) begin
						o = '0;
						res.push_back(o);
					end
				end
			end
			FUNC_WAKE_POST: begin
				wake_flag = 1'b1;
				res.push_back(o);
			end
			default: begin
				wake_flag = 1'b0;
				res.push_back(o);
			end
		endcase
		nd = earliest();
		foreach (res[k]) begin
			res[k].next_due = nd;
			res[k].last = (k == res.size() - 1);
			expected_q.push_back(res[k]);
		end
	endtask

	// watch both channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		outcome_t got;
		if (!arst_n) begin
			stored_count = 0;
			wake_flag = 1'b0;
			fail_count = 0;
			expected_q.delete();
		end else begin
			if (strobe) begin
				got = '{status, result_kind, result_tag, result_value, last, next_due};
				if (expected_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result %h", got);
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("mismatch: exp st=%0d k=%0d tag=%h val=%h last=%b nd=%h",
								want.status, want.kind, want.tag, want.value, want.last,
								want.next_due);
							$display("          got st=%0d k=%0d tag=%h val=%h last=%b nd=%h",
								got.status, got.kind, got.tag, got.value, got.last,
								got.next_due);
						end
					end
				end
			end
			if (start && !busy)
				predict_request();
		end
	end

endmodule

### tb/sv/timed_event_queue_core_tb.sv
// testbench top: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps
module timed_event_queue_core_tb import teq_pkg::*;;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         func;
	logic [62:0]        due_time;
	logic [1:0]         event_kind;
	logic [31:0]        event_tag;
	logic signed [31:0] event_value;
	logic               swizzle_coin;
	logic [62:0]        now_time;
	logic [5:0]         max_events;
	logic               strobe;
	logic [1:0]         status;
	logic [2:0]         result_kind;
	logic [31:0]        result_tag;
	logic signed [31:0] result_value;
	logic               last;
	logic signed [63:0] next_due;
	int                 fail_count;
	int                 pending;
	logic [62:0]        time_base;
	logic               gaps_on;

	timed_event_queue_core u_top (.*);

	timed_event_queue_checker u_checker (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("TB_ERROR");
		$finish;
	end

	// wait for acceptance of one request transaction, then maybe idle
	task automatic send_request(input logic [1:0] f, input logic [62:0] due,
		input logic [1:0] kind, input logic [31:0] tag, input logic [31:0] val,
		input logic coin, input logic [62:0] now, input logic [5:0] maxev);
		int gap;
		func = f;
		due_time = due;
		event_kind = kind;
		event_tag = tag;
		event_value = val;
		swizzle_coin = coin;
		now_time = now;
		max_events = maxev;
		start = 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
		start = 1'b0;
		if (gaps_on && $urandom_range(0, 2) == 0) begin
			gap = $urandom_range(1, 13);
			repeat (gap) @(negedge clk);
		end
	endtask

	function automatic logic [62:0] rand63();
		return 63'({$urandom(), $urandom()});
	endfunction

	// random transaction, mostly inserts and polls with clustered due times
	task automatic send_random();
		int sel;
		logic [62:0] due;
		sel = $urandom_range(0, 99);
		if ($urandom_range(0, 9) == 0)
			due = rand63();
		else
			due = time_base + 63'($urandom_range(0, 40));
		if (sel < 50)
			send_request(FUNC_INSERT, due,
				($urandom_range(0, 19) == 0) ? EV_BAD : 2'($urandom_range(0, 2)),
				$urandom(), $urandom(), 1'($urandom_range(0, 1)), rand63(),
				6'($urandom()));
		else if (sel < 80) begin
			send_request(FUNC_POLL, rand63(), 2'($urandom()), $urandom(), $urandom(),
				1'($urandom_range(0, 1)),
				($urandom_range(0, 9) == 0) ? rand63() :
					time_base + 63'($urandom_range(0, 40)),
				($urandom_range(0, 9) == 0) ? 6'($urandom()) : 6'($urandom_range(1, 4)));
			time_base = time_base + 63'($urandom_range(0, 10));
		end else if (sel < 90)
			send_request(FUNC_WAKE_POST, rand63(), 2'($urandom()), $urandom(), $urandom(),
				1'($urandom_range(0, 1)), rand63(), 6'($urandom()));
		else
			send_request(FUNC_WAKE_CLEAR, rand63(), 2'($urandom()), $urandom(), $urandom(),
				1'($urandom_range(0, 1)), rand63(), 6'($urandom()));
	endtask

	initial begin
		int guard;
		arst_n = 1'b0;
		start = 1'b0;
		func = FUNC_INSERT;
		due_time = '0;
		event_kind = EV_READY;
		event_tag = '0;
		event_value = '0;
		swizzle_coin = 1'b0;
		now_time = '0;
		max_events = '0;
		gaps_on = 1'b1;
		time_base = 63'd1000;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// directed: empty poll, zero slot limit, wakeup post and clear, invalid insert
		send_request(FUNC_POLL, '0, EV_READY, '0, '0, 1'b0, '1, 6'd1);
		send_request(FUNC_POLL, '0, EV_READY, '0, '0, 1'b0, '1, 6'd0);
		send_request(FUNC_WAKE_POST, '1, EV_BAD, '1, '1, 1'b1, '1, '1);
		send_request(FUNC_WAKE_CLEAR, '0, EV_READY, '0, '0, 1'b0, '0, '0);
		send_request(FUNC_WAKE_POST, '0, EV_READY, '0, '0, 1'b0, '0, '0);
		send_request(FUNC_INSERT, 63'd5, EV_BAD, 32'h1, 32'h1, 1'b0, '0, '0);
		// fill the queue past full with equal times and swizzle
		for (int i = 0; i < 17; i++)
			send_request(FUNC_INSERT, (i == 3) ? '1 : (i == 4) ? '0 : 63'(i % 3),
				2'(i % 3), (i == 0) ? '1 : 32'(i), (i == 1) ? 32'h80000000 : 32'h7fffffff,
				i[0], '0, '0);
		// wakeup first, then exhausted slots, then oversized limit
		send_request(FUNC_POLL, '0, EV_READY, '0, '0, 1'b0, 63'd1, 6'd2);
		send_request(FUNC_POLL, '0, EV_READY, '0, '0, 1'b0, '1, 6'd63);

		// random part; last stretch has no idling
		for (int n = 0; n < 96; n++) begin
			if (n == 80)
				gaps_on = 1'b0;
			if (n == 48) begin
				guard = 0;
				while (pending != 0 && guard < 10000) begin
					@(negedge clk);
					guard++;
				end
			end
			send_random();
		end

		guard = 0;
		while (pending != 0 && guard < 100000) begin
			@(negedge clk);
			guard++;
		end
		repeat (100) @(negedge clk);
		if (pending == 0 && fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### timed_event_queue_core.f
src/teq_pkg.sv
src/teq_dp.sv
src/teq_ctrl.sv
src/timed_event_queue_core.sv
tb/sv/timed_event_queue_checker.sv
tb/sv/timed_event_queue_core_tb.sv
